FILE: rtl/core/utf8d_pkg.sv
// Shared types, codes and lookup functions for the UTF-8 stream decoder.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package utf8d_pkg;

  // Input opcodes
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Result kinds
  localparam logic KIND_CHAR    = 1'b0;
  localparam logic KIND_ILLEGAL = 1'b1;

  localparam int unsigned CP_W       = 31;
  localparam int unsigned ACC_W      = 32;
  localparam int unsigned OBUF_DEPTH = 4;
  localparam int unsigned OBUF_AW    = $clog2(OBUF_DEPTH);

  typedef struct packed {
    logic            kind;
    logic [CP_W-1:0] code_point;
    logic            last;
  } utf8d_result_t;

  // Results produced by one accepted request, in delivery order
  typedef struct packed {
    logic [1:0]    count;
    utf8d_result_t first;
    utf8d_result_t second;
  } utf8d_push_t;

  // Expected sequence length from a lead byte; zero means not a lead byte
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (b < 8'h80)      len = 3'd1;
    else if (b < 8'hC0) len = 3'd0;
    else if (b < 8'hE0) len = 3'd2;
    else if (b < 8'hF0) len = 3'd3;
    else if (b < 8'hF8) len = 3'd4;
    else if (b < 8'hFC) len = 3'd5;
    else if (b < 8'hFE) len = 3'd6;
    else                len = 3'd0;
    return len;
  endfunction

  function automatic logic [ACC_W-1:0] marker_of(input logic [2:0] idx);
    logic [ACC_W-1:0] m;
    unique case (idx)
      3'd0:    m = 32'h0000_3080;
      3'd1:    m = 32'h000E_2080;
      3'd2:    m = 32'h03C8_2080;
      3'd3:    m = 32'hFA08_2080;
      3'd4:    m = 32'h8208_2080;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [ACC_W-1:0] overlong_of(input logic [2:0] idx);
    logic [ACC_W-1:0] m;
    unique case (idx)
      3'd0:    m = 32'hFFFF_FFC0;
      3'd1:    m = 32'hFFFF_F000;
      3'd2:    m = 32'hFFFC_0000;
      3'd3:    m = 32'hFF00_0000;
      3'd4:    m = 32'hC000_0000;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/utf8d_step.sv
// Per-request decode step: sequence state registers and the logic that
// turns one request into zero, one or two results. Depends on utf8d_pkg.
`default_nettype none

module utf8d_step
  import utf8d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic        opcode,
  input  wire logic [7:0]  byte_value,
  output utf8d_push_t      push
);

  logic [2:0]       bytes_seen_r, bytes_seen_nxt;
  logic [2:0]       seq_len_r, seq_len_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;

  logic             is_cont;
  logic             pre_illegal;
  logic [2:0]       seen0;
  logic [2:0]       seen1;
  logic [2:0]       len0;
  logic [2:0]       idx;
  logic [ACC_W-1:0] acc0, acc1, acc2;
  logic             main_valid;
  logic             main_kind;
  logic [CP_W-1:0]  main_cp;
  utf8d_result_t    res_pre, res_main;

  always_comb begin
    bytes_seen_nxt = bytes_seen_r;
    seq_len_nxt    = seq_len_r;
    acc_nxt        = acc_r;
    main_valid     = 1'b0;
    main_kind      = KIND_ILLEGAL;
    main_cp        = '0;

    is_cont     = (byte_value[7:6] == 2'b10);
    pre_illegal = (opcode == OP_FLUSH || !is_cont) && (bytes_seen_r != 3'd0);
    seen0       = is_cont ? bytes_seen_r : 3'd0;
    len0        = (seen0 == 3'd0) ? lead_length(byte_value) : seq_len_r;
    acc0        = (seen0 == 3'd0) ? '0 : acc_r;
    acc1        = {acc0[ACC_W-7:0], 6'b0} ^ {{(ACC_W-8){1'b0}}, byte_value};
    seen1       = seen0 + 3'd1;
    idx         = len0 - 3'd2;
    acc2        = acc1 ^ marker_of(idx);

    if (opcode == OP_FLUSH) begin
      bytes_seen_nxt = 3'd0;
    end else begin
      seq_len_nxt = len0;
      if (len0 == 3'd0) begin
        main_valid     = 1'b1;
        bytes_seen_nxt = 3'd0;
        acc_nxt        = acc0;
      end else if (len0 == 3'd1) begin
        main_valid     = 1'b1;
        main_kind      = KIND_CHAR;
        main_cp        = {{(CP_W-8){1'b0}}, byte_value};
        bytes_seen_nxt = 3'd0;
        acc_nxt        = acc0;
      end else if (seen1 == len0) begin
        // Sequence complete: flip markers, then check the overlong mask
        main_valid     = 1'b1;
        bytes_seen_nxt = 3'd0;
        acc_nxt        = acc2;
        if ((acc2 & overlong_of(idx)) != '0) begin
          main_kind = KIND_CHAR;
          main_cp   = acc2[CP_W-1:0];
        end
      end else begin
        bytes_seen_nxt = seen1;
        acc_nxt        = acc1;
      end
    end

    res_pre  = '{kind: KIND_ILLEGAL, code_point: '0, last: !main_valid};
    res_main = '{kind: main_kind, code_point: main_cp, last: 1'b1};

    if (pre_illegal) begin
      push.first  = res_pre;
      push.second = res_main;
    end else begin
      push.first  = res_main;
      push.second = res_main;
    end
    push.count = accept ? ({1'b0, pre_illegal} + {1'b0, main_valid}) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r <= 3'd0;
      seq_len_r    <= 3'd0;
      acc_r        <= '0;
    end else if (accept) begin
      bytes_seen_r <= bytes_seen_nxt;
      seq_len_r    <= seq_len_nxt;
      acc_r        <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/utf8d_obuf.sv
// Result queue: takes up to two results per cycle and delivers one per
// cycle while out_ready is high. Depends on utf8d_pkg.
`default_nettype none

module utf8d_obuf
  import utf8d_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire utf8d_push_t push,
  output logic           room,
  output logic           out_valid,
  input  wire logic      out_ready,
  output utf8d_result_t  out_res
);

  localparam logic [OBUF_AW:0] ROOM_MAX = (OBUF_AW+1)'(OBUF_DEPTH - 2);

  utf8d_result_t        mem [OBUF_DEPTH];
  logic [OBUF_AW-1:0]   wptr_r, rptr_r;
  logic [OBUF_AW:0]     count_r, count_nxt;
  logic                 pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign room      = (count_r <= ROOM_MAX);
  assign out_res   = mem[rptr_r];
  assign count_nxt = count_r + {{(OBUF_AW-1){1'b0}}, push.count}
                     - {{OBUF_AW{1'b0}}, pop};

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wptr_r + OBUF_AW'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_r + OBUF_AW'(push.count);
      rptr_r  <= rptr_r + OBUF_AW'(pop);
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder (legacy 5- and 6-byte forms too).
// Depends on utf8d_pkg, utf8d_step and utf8d_obuf.
`default_nettype none

//  channel  | direction | tdata                  | tuser        | tlast
//  ---------+-----------+------------------------+--------------+-------------
//  in_      | slave     | [7:0] byte_value       | opcode       | (none)
//  out_     | master    | [30:0] code_point, pad | kind         | last result
//
// One request is decoded in the cycle it is accepted; its results are
// registered into a four-entry result queue and leave at one result per
// cycle while out_tready is high. A request is taken every cycle while the
// queue has room for two results; a request that yields two results (an
// illegal report followed by the result for the new byte) fills two slots
// and leaves as two output beats. Stalls on out_ only fill the queue;
// in_tready drops when fewer than two slots are free. Reset (rst_n low,
// synchronous) clears the sequence state and empties the queue.

module utf8_stream_decoder_unit
  import utf8d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_value
  input  wire logic        in_tuser,   // [0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [30:0] code_point, [31] zero
  output logic             out_tuser,  // [0] kind
  output logic             out_tlast
);

  logic          accept;
  logic          room;
  utf8d_push_t   push;
  utf8d_result_t out_res;

  // Take a request only while two result slots are free
  assign in_tready = room;
  assign accept    = in_tvalid && in_tready;

  utf8d_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .opcode     (in_tuser),
    .byte_value (in_tdata),
    .push       (push)
  );

  utf8d_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Unpack the queue head onto the stream fields
  assign out_tdata = {1'b0, out_res.code_point};
  assign out_tuser = out_res.kind;
  assign out_tlast = out_res.last;

endmodule

`default_nettype wire
